// ===== hw/rtl/fbs_pkg.sv =====
// Shared constants and field layout of the Fourier burst synthesizer.
`default_nettype none

package fbs_pkg;

   // Command codes carried in the request tuser.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;

   // Register indexes of the configuration port.
   localparam int          CSR_IDX_W      = 2;
   localparam int          CSR_DATA_W     = 16;
   localparam logic [1:0]  CSR_BASE_FREQ  = 2'd0;
   localparam logic [1:0]  CSR_FREQ_STEP  = 2'd1;
   localparam logic [1:0]  CSR_BURST_LEN  = 2'd2;
   localparam logic [1:0]  CSR_HARM_USED  = 2'd3;

   // Register widths and reset values.
   localparam int           BASE_W         = 15;
   localparam int           STEP_W         = 10;
   localparam int           BURST_W        = 16;
   localparam int           HUSED_W        = 5;
   localparam logic [14:0]  BASE_RESET     = 15'd70;
   localparam logic [9:0]   STEP_RESET     = 10'd5;
   localparam logic [15:0]  BURST_RESET    = 16'd10000;
   localparam logic [4:0]   HUSED_RESET    = 5'd16;

   // Request word layout.
   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 56;
   localparam int HIDX_W     = 4;
   localparam int COEF_W     = 16;
   localparam int HIDX_LSB   = 0;
   localparam int COS_LSB    = 4;
   localparam int SIN_LSB    = 20;
   localparam int DC_LSB     = 36;

   // Response word layout.
   localparam int RSP_DATA_W = 24;

   // Sine table generation in Q30.
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;
   localparam longint unsigned HALF_Q30    = 64'd1 << 29;
   localparam longint unsigned SINE_SCALE  = 64'd32767;
   localparam longint unsigned TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                   64'd42, 64'd20, 64'd6};

   // Output scaling and saturation.
   localparam int              DC_SHIFT    = 14;
   localparam int              ROUND_SHIFT = 15;
   localparam int              ROUND_BIAS  = 16384;
   localparam longint          SAMPLE_MAX  = 64'sd8388607;
   localparam longint          SAMPLE_MIN  = -64'sd8388608;

endpackage

`default_nettype wire

// ===== hw/rtl/fourier_burst_synthesizer_unit.sv =====
// Additive Fourier-series burst synthesizer: sequencer, shared harmonic pipeline and tables.
`default_nettype none

// Load and start words, and a tick that arrives with no burst armed, are taken in the idle
// state without leaving it. A tick during a burst first folds the base frequency and the
// step below the sample rate by repeated subtraction, then issues one harmonic per cycle
// through a shared seven-stage pipeline that advances the phase, converts it to a table
// index, reads the quarter-wave table and multiplies by both coefficients, and then
// rounds and saturates the sum. The block takes the next word while a finished sample
// still waits on the response side, but a further tick holds the block in its finishing
// state until that sample is taken.
module fourier_burst_synthesizer_unit #(
   parameter int HARMONICS        = 16,
   parameter int SAMPLE_RATE_HZ   = 100000,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // harmonic_index, cos_coeff, sin_coeff, dc_term, zero fill
   input  wire logic [fbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  wire logic [fbs_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // sample
   output logic [fbs_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_we,
   input  wire logic [fbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fbs_pkg::*;

   localparam int RW     = $clog2(SAMPLE_RATE_HZ);
   localparam int RED_W  = (RW + 1 > BASE_W) ? RW + 1 : BASE_W;
   localparam int KW     = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
   localparam int CNTW   = $clog2(HARMONICS + 1);
   localparam int AW     = $clog2(SINE_TABLE_DEPTH);
   localparam int IW     = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int QW     = IW + 1;
   localparam int CW     = IW + 2;
   localparam int ACC_W  = 32 + $clog2(HARMONICS) + 2;
   localparam int STAGES = 7;
   localparam longint unsigned FOURD = 4 * SINE_TABLE_DEPTH;
   localparam longint unsigned RATE  = SAMPLE_RATE_HZ;
   localparam longint unsigned RECIP = ((FOURD << RW) + RATE - 1) / RATE;

   typedef logic [15:0] rom_type [SINE_TABLE_DEPTH];

   typedef struct packed {
      logic          vld;
      logic          active;
      logic [KW-1:0] k;
   } stage_ctl_type;

   typedef struct packed {
      logic          neg;
      logic [AW-1:0] addr;
   } wave_ref_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_RUN,
      ST_FINISH
   } state_type;

   function automatic rom_type build_rom();
      rom_type           rom;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   t;
      longint unsigned   s;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         x  = (longint'(2 * i + 1) * PI_Q30) / FOURD;
         x2 = (x * x) >> 30;
         t  = ONE_Q30;
         for (int j = 0; j < 6; j++) begin
            t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[j];
         end
         s      = (x * t) >> 30;
         rom[i] = 16'((s * SINE_SCALE + HALF_Q30) >> 30);
      end
      return rom;
   endfunction

   function automatic wave_ref_type wave_ref(input logic [IW-1:0] idx);
      logic [1:0]    quad;
      logic [IW-1:0] r;
      wave_ref_type  w;
      quad = {1'b0, idx >= IW'(SINE_TABLE_DEPTH)}
           + {1'b0, idx >= IW'(2 * SINE_TABLE_DEPTH)}
           + {1'b0, idx >= IW'(3 * SINE_TABLE_DEPTH)};
      case (quad)
         2'd0: r = idx;
         2'd1: r = idx - IW'(SINE_TABLE_DEPTH);
         2'd2: r = idx - IW'(2 * SINE_TABLE_DEPTH);
         default: r = idx - IW'(3 * SINE_TABLE_DEPTH);
      endcase
      w.addr = quad[0] ? AW'(SINE_TABLE_DEPTH - 1) - r[AW-1:0] : r[AW-1:0];
      w.neg  = quad[1];
      return w;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Control state.
   state_type               state_ff;
   logic                    armed_ff;
   logic signed [COEF_W-1:0] dc_ff;
   logic [BURST_W-1:0]      elapsed_ff;
   logic [BASE_W-1:0]       base_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [BURST_W-1:0]      burst_ff;
   logic [HUSED_W-1:0]      hused_ff;
   logic [RED_W-1:0]        red_base_ff;
   logic [RED_W-1:0]        red_step_ff;
   logic [RW-1:0]           fk_ff;
   logic [RW-1:0]           step_r_ff;
   logic [CNTW-1:0]         cnt_ff;
   logic [CNTW-1:0]         nh_ff;
   logic                    ph_vld_ff [HARMONICS];
   stage_ctl_type           st_ff [1:STAGES];
   logic                    rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;
   logic                    rsp_tlast_ff;

   // Memories.
   logic [RW-1:0]            phase_mem [HARMONICS];
   logic signed [COEF_W-1:0] cos_tab [HARMONICS];
   logic signed [COEF_W-1:0] sin_tab [HARMONICS];

   // Pipeline data.
   logic [RW-1:0]            ph_rd_ff;
   logic                     ph_ok_ff;
   logic [RW-1:0]            p_ff;
   logic [RW+CW-1:0]         prod1_ff;
   logic [RW+IW-1:0]         pd_ff;
   logic [QW-1:0]            q0_ff;
   logic [QW+RW-1:0]         qr_ff;
   logic [RW+IW-1:0]         pd3_ff;
   wave_ref_type             s_ref_ff;
   wave_ref_type             c_ref_ff;
   logic [15:0]              s_rom_ff;
   logic [15:0]              c_rom_ff;
   logic                     s_neg_ff;
   logic                     c_neg_ff;
   logic signed [COEF_W-1:0] cos_rd_ff;
   logic signed [COEF_W-1:0] sin_rd_ff;
   logic signed [31:0]       prod_c_ff;
   logic signed [31:0]       prod_s_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // Combinational signals.
   logic                     req_fire;
   logic [1:0]               cmd;
   logic [HIDX_W-1:0]        hidx;
   logic [KW-1:0]            load_addr;
   logic                     tick_go;
   logic                     issue;
   logic [KW-1:0]            issue_k;
   logic [RW-1:0]            ph_prev;
   logic [RW:0]              ph_sum;
   logic [RW-1:0]            ph_new;
   logic [RW:0]              fk_sum;
   logic [RW-1:0]            fk_next;
   logic [QW-1:0]            q0;
   logic                     corr;
   logic [IW-1:0]            idx_s;
   logic [IW:0]              idx_c_sum;
   logic [IW-1:0]            idx_c;
   logic signed [15:0]       s_wave;
   logic signed [15:0]       c_wave;
   logic signed [ACC_W:0]    rnd;
   logic signed [ACC_W-ROUND_SHIFT:0] y;
   logic signed [63:0]       y64;
   logic [RSP_DATA_W-1:0]    sample_sat;
   logic [CNTW-1:0]          nh_calc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = req_tuser;
   assign hidx       = req_tdata[HIDX_LSB +: HIDX_W];
   assign load_addr  = KW'(hidx);
   assign tick_go    = req_fire && (cmd == CMD_TICK) && armed_ff;
   assign issue      = (state_ff == ST_RUN) && (cnt_ff < CNTW'(HARMONICS));
   assign issue_k    = cnt_ff[KW-1:0];
   assign nh_calc    = (32'(hused_ff) > HARMONICS) ? CNTW'(HARMONICS) : CNTW'(hused_ff);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   always_comb begin
      ph_prev   = ph_ok_ff ? ph_rd_ff : '0;
      ph_sum    = {1'b0, ph_prev} + {1'b0, fk_ff};
      ph_new    = (ph_sum >= (RW+1)'(SAMPLE_RATE_HZ))
                ? RW'(ph_sum - (RW+1)'(SAMPLE_RATE_HZ)) : ph_sum[RW-1:0];
      fk_sum    = {1'b0, fk_ff} + {1'b0, step_r_ff};
      fk_next   = (fk_sum >= (RW+1)'(SAMPLE_RATE_HZ))
                ? RW'(fk_sum - (RW+1)'(SAMPLE_RATE_HZ)) : fk_sum[RW-1:0];
      q0        = prod1_ff[RW +: QW];
      corr      = qr_ff > (QW+RW)'(pd3_ff);
      idx_s     = IW'(q0_ff - QW'(corr));
      idx_c_sum = {1'b0, idx_s} + (IW+1)'(SINE_TABLE_DEPTH);
      idx_c     = (idx_c_sum >= (IW+1)'(FOURD))
                ? IW'(idx_c_sum - (IW+1)'(FOURD)) : idx_c_sum[IW-1:0];
      s_wave    = s_neg_ff ? -$signed(s_rom_ff) : $signed(s_rom_ff);
      c_wave    = c_neg_ff ? -$signed(c_rom_ff) : $signed(c_rom_ff);
      rnd       = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(ROUND_BIAS);
      y         = rnd[ACC_W:ROUND_SHIFT];
      y64       = 64'(y);
      if (y64 > SAMPLE_MAX) begin
         sample_sat = RSP_DATA_W'(SAMPLE_MAX);
      end else if (y64 < SAMPLE_MIN) begin
         sample_sat = RSP_DATA_W'(SAMPLE_MIN);
      end else begin
         sample_sat = y64[RSP_DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         armed_ff      <= 1'b0;
         dc_ff         <= '0;
         elapsed_ff    <= '0;
         base_ff       <= BASE_RESET;
         step_ff       <= STEP_RESET;
         burst_ff      <= BURST_RESET;
         hused_ff      <= HUSED_RESET;
         red_base_ff   <= '0;
         red_step_ff   <= '0;
         fk_ff         <= '0;
         step_r_ff     <= '0;
         cnt_ff        <= '0;
         nh_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tdata_ff  <= '0;
         rsp_tlast_ff  <= 1'b0;
         for (int i = 0; i < HARMONICS; i++) begin
            ph_vld_ff[i] <= 1'b0;
         end
         for (int i = 1; i <= STAGES; i++) begin
            st_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_FREQ: base_ff  <= csr_wdata[BASE_W-1:0];
               CSR_FREQ_STEP: step_ff  <= csr_wdata[STEP_W-1:0];
               CSR_BURST_LEN: burst_ff <= csr_wdata[BURST_W-1:0];
               CSR_HARM_USED: hused_ff <= csr_wdata[HUSED_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_FINISH) begin
            rsp_tvalid_ff <= 1'b0;
         end

         st_ff[1].vld    <= issue;
         st_ff[1].active <= cnt_ff < nh_ff;
         st_ff[1].k      <= issue_k;
         for (int i = 2; i <= STAGES; i++) begin
            st_ff[i] <= st_ff[i-1];
         end

         if (st_ff[1].vld) begin
            ph_vld_ff[st_ff[1].k] <= 1'b1;
            fk_ff                 <= fk_next;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (cmd)
                     CMD_START: begin
                        dc_ff      <= req_tdata[DC_LSB +: COEF_W];
                        elapsed_ff <= '0;
                        armed_ff   <= 1'b1;
                        for (int i = 0; i < HARMONICS; i++) begin
                           ph_vld_ff[i] <= 1'b0;
                        end
                     end
                     CMD_TICK: begin
                        if (armed_ff) begin
                           elapsed_ff  <= elapsed_ff + 1'b1;
                           red_base_ff <= RED_W'(base_ff);
                           red_step_ff <= RED_W'(step_ff);
                           nh_ff       <= nh_calc;
                           state_ff    <= ST_REDUCE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_REDUCE: begin
               if (red_base_ff >= RED_W'(SAMPLE_RATE_HZ)) begin
                  red_base_ff <= red_base_ff - RED_W'(SAMPLE_RATE_HZ);
               end
               if (red_step_ff >= RED_W'(SAMPLE_RATE_HZ)) begin
                  red_step_ff <= red_step_ff - RED_W'(SAMPLE_RATE_HZ);
               end
               if (red_base_ff < RED_W'(SAMPLE_RATE_HZ) &&
                   red_step_ff < RED_W'(SAMPLE_RATE_HZ)) begin
                  fk_ff     <= red_base_ff[RW-1:0];
                  step_r_ff <= red_step_ff[RW-1:0];
                  cnt_ff    <= '0;
                  state_ff  <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end else if (!st_ff[1].vld && !st_ff[2].vld && !st_ff[3].vld &&
                            !st_ff[4].vld && !st_ff[5].vld && !st_ff[6].vld &&
                            !st_ff[7].vld) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= sample_sat;
                  rsp_tlast_ff  <= elapsed_ff >= burst_ff;
                  if (elapsed_ff >= burst_ff) begin
                     armed_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (cmd == CMD_LOAD) && (32'(hidx) < HARMONICS)) begin
         cos_tab[load_addr] <= req_tdata[COS_LSB +: COEF_W];
         sin_tab[load_addr] <= req_tdata[SIN_LSB +: COEF_W];
      end
      cos_rd_ff <= cos_tab[st_ff[5].k];
      sin_rd_ff <= sin_tab[st_ff[5].k];
   end

   always_ff @(posedge clock) begin
      if (st_ff[1].vld) begin
         phase_mem[st_ff[1].k] <= ph_new;
      end
      ph_rd_ff <= phase_mem[issue_k];
      ph_ok_ff <= ph_vld_ff[issue_k];
   end

   always_ff @(posedge clock) begin
      s_rom_ff <= SINE_ROM[s_ref_ff.addr];
      c_rom_ff <= SINE_ROM[c_ref_ff.addr];
   end

   always_ff @(posedge clock) begin
      p_ff      <= ph_new;
      prod1_ff  <= (RW+CW)'(p_ff) * (RW+CW)'(RECIP);
      pd_ff     <= (RW+IW)'(p_ff) * (RW+IW)'(FOURD);
      q0_ff     <= q0;
      qr_ff     <= (QW+RW)'(q0) * (QW+RW)'(RATE);
      pd3_ff    <= pd_ff;
      s_ref_ff  <= wave_ref(idx_s);
      c_ref_ff  <= wave_ref(idx_c);
      s_neg_ff  <= s_ref_ff.neg;
      c_neg_ff  <= c_ref_ff.neg;
      prod_c_ff <= cos_rd_ff * c_wave;
      prod_s_ff <= sin_rd_ff * s_wave;
      if (tick_go) begin
         acc_ff <= ACC_W'(dc_ff) <<< DC_SHIFT;
      end else if (st_ff[7].vld && st_ff[7].active) begin
         acc_ff <= acc_ff + ACC_W'(prod_c_ff) + ACC_W'(prod_s_ff);
      end
   end

endmodule

`default_nettype wire
